// ===== hdl/dsre_pkg.sv =====
`timescale 1ns / 1ps

package dsre_pkg;

	localparam int DEPTH_DEF = 512;
	localparam int DATA_W    = 32;
	localparam int CNT_OUT_W = 10;

	// action codes
	localparam logic [3:0] ACT_LOAD    = 4'd0;
	localparam logic [3:0] ACT_SWAP_A  = 4'd1;
	localparam logic [3:0] ACT_SWAP_B  = 4'd2;
	localparam logic [3:0] ACT_SWAP_AB = 4'd3;
	localparam logic [3:0] ACT_ROT_A   = 4'd4;
	localparam logic [3:0] ACT_ROT_B   = 4'd5;
	localparam logic [3:0] ACT_ROT_AB  = 4'd6;
	localparam logic [3:0] ACT_REV_A   = 4'd7;
	localparam logic [3:0] ACT_REV_B   = 4'd8;
	localparam logic [3:0] ACT_REV_AB  = 4'd9;
	localparam logic [3:0] ACT_MOVE_BA = 4'd10;
	localparam logic [3:0] ACT_MOVE_AB = 4'd11;

	// status codes
	localparam logic [1:0] STS_DONE      = 2'd0;
	localparam logic [1:0] STS_IGNORED   = 2'd1;
	localparam logic [1:0] STS_POP_EMPTY = 2'd2;

	typedef struct packed {
		logic [3:0]               action;
		logic signed [DATA_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic [1:0]               status;
		logic signed [DATA_W-1:0] a_top_value;
		logic signed [DATA_W-1:0] b_top_value;
		logic [CNT_OUT_W-1:0]     a_count;
		logic [CNT_OUT_W-1:0]     b_count;
	} rsp_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_LOAD,
		OP_SWAP,
		OP_ROT,
		OP_REV,
		OP_MOVE_BA,
		OP_MOVE_AB
	} op_kind_t;

	// classified request as held in the queue
	typedef struct packed {
		op_kind_t                 kind;
		logic                     on_a;
		logic                     on_b;
		logic signed [DATA_W-1:0] value;
	} op_t;

	typedef enum logic [2:0] {
		SC_NONE,
		SC_PUSH,
		SC_POP,
		SC_SWAP,
		SC_ROT,
		SC_REV
	} stk_cmd_t;

	// back end to one stack
	typedef struct packed {
		stk_cmd_t                 cmd;
		logic                     fin;
		logic signed [DATA_W-1:0] push_val;
	} stk_ctl_t;

	// one stack to back end
	typedef struct packed {
		logic                     empty;
		logic                     ge2;
		logic                     full;
		logic signed [DATA_W-1:0] top;
		logic signed [DATA_W-1:0] top_next;
		logic [CNT_OUT_W-1:0]     cnt_next;
	} stk_view_t;

	typedef enum logic {
		BK_IDLE,
		BK_EXEC
	} bk_state_t;

endpackage

// ===== hdl/dsre_ram.sv =====
`timescale 1ns / 1ps

module dsre_ram #(
	parameter int WIDTH = dsre_pkg::DATA_W,
	parameter int DEPTH = dsre_pkg::DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// read returns old data on a same-address write
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// ===== hdl/dsre_front.sv =====
`timescale 1ns / 1ps

module dsre_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  dsre_pkg::req_t  req,
	input  logic            pop,
	output dsre_pkg::op_t   head,
	output logic            head_valid
);

	dsre_pkg::op_t q_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    cnt_q;
	dsre_pkg::op_t op_dec;
	logic          push;

	always_comb begin
		op_dec.kind  = dsre_pkg::OP_NONE;
		op_dec.on_a  = 1'b0;
		op_dec.on_b  = 1'b0;
		op_dec.value = req.value;
		unique case (req.action) inside
			dsre_pkg::ACT_LOAD: begin
				op_dec.kind = dsre_pkg::OP_LOAD;
				op_dec.on_a = 1'b1;
			end
			dsre_pkg::ACT_SWAP_A, dsre_pkg::ACT_SWAP_B, dsre_pkg::ACT_SWAP_AB: begin
				op_dec.kind = dsre_pkg::OP_SWAP;
			end
			dsre_pkg::ACT_ROT_A, dsre_pkg::ACT_ROT_B, dsre_pkg::ACT_ROT_AB: begin
				op_dec.kind = dsre_pkg::OP_ROT;
			end
			dsre_pkg::ACT_REV_A, dsre_pkg::ACT_REV_B, dsre_pkg::ACT_REV_AB: begin
				op_dec.kind = dsre_pkg::OP_REV;
			end
			dsre_pkg::ACT_MOVE_BA: begin
				op_dec.kind = dsre_pkg::OP_MOVE_BA;
			end
			dsre_pkg::ACT_MOVE_AB: begin
				op_dec.kind = dsre_pkg::OP_MOVE_AB;
			end
			default: begin
				op_dec.kind = dsre_pkg::OP_NONE;
			end
		endcase
		// stack selection for swap / rotate / reverse
		unique case (req.action) inside
			dsre_pkg::ACT_SWAP_A, dsre_pkg::ACT_ROT_A, dsre_pkg::ACT_REV_A: begin
				op_dec.on_a = 1'b1;
			end
			dsre_pkg::ACT_SWAP_B, dsre_pkg::ACT_ROT_B, dsre_pkg::ACT_REV_B: begin
				op_dec.on_b = 1'b1;
			end
			dsre_pkg::ACT_SWAP_AB, dsre_pkg::ACT_ROT_AB, dsre_pkg::ACT_REV_AB: begin
				op_dec.on_a = 1'b1;
				op_dec.on_b = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign req_stall  = (cnt_q == 2'd2);
	assign push       = req_valid && !req_stall;
	assign head       = q_q[rd_ptr_q];
	assign head_valid = (cnt_q != 2'd0);

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wr_ptr_q] <= op_dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

// ===== hdl/dsre_stack.sv =====
`timescale 1ns / 1ps

module dsre_stack #(
	parameter int DEPTH = dsre_pkg::DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  dsre_pkg::stk_ctl_t  ctl,
	output dsre_pkg::stk_view_t view
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = AW + 1;
	localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
	localparam logic [SW-1:0] DEPTH_S  = SW'(DEPTH);

	function automatic logic [AW-1:0] inc_idx(input logic [AW-1:0] i);
		return (i == LAST_IDX) ? '0 : i + AW'(1);
	endfunction

	function automatic logic [AW-1:0] dec_idx(input logic [AW-1:0] i);
		return (i == '0) ? LAST_IDX : i - AW'(1);
	endfunction

	// top entry lives in top_q; its RAM slot is stale until flushed
	logic [AW-1:0]                  bot_q;
	logic [CW-1:0]                  sz_q;
	logic signed [dsre_pkg::DATA_W-1:0] top_q;

	logic [SW-1:0]                  top_sum;
	logic [AW-1:0]                  top_idx;
	logic [AW-1:0]                  below_idx;
	logic [AW-1:0]                  bot_dec;
	logic [AW-1:0]                  bot_inc;

	logic                           wr_en;
	logic [AW-1:0]                  wr_addr;
	logic [AW-1:0]                  rd_addr;
	logic [dsre_pkg::DATA_W-1:0]    rd_data;

	logic [AW-1:0]                  bot_d;
	logic [CW-1:0]                  sz_d;
	logic signed [dsre_pkg::DATA_W-1:0] top_d;

	assign top_sum   = SW'(bot_q) + SW'(sz_q - CW'(1));
	assign top_idx   = (top_sum >= DEPTH_S) ? AW'(top_sum - DEPTH_S) : AW'(top_sum);
	assign below_idx = dec_idx(top_idx);
	assign bot_dec   = dec_idx(bot_q);
	assign bot_inc   = inc_idx(bot_q);

	always_comb begin
		rd_addr = below_idx;
		wr_en   = 1'b0;
		wr_addr = top_idx;
		bot_d   = bot_q;
		sz_d    = sz_q;
		top_d   = top_q;
		unique case (ctl.cmd)
			dsre_pkg::SC_PUSH: begin
				wr_en = ctl.fin && (sz_q != '0);
				sz_d  = sz_q + CW'(1);
				top_d = ctl.push_val;
			end
			dsre_pkg::SC_POP: begin
				sz_d  = sz_q - CW'(1);
				top_d = rd_data;
			end
			dsre_pkg::SC_SWAP: begin
				wr_en   = ctl.fin;
				wr_addr = below_idx;
				top_d   = rd_data;
			end
			dsre_pkg::SC_ROT: begin
				wr_en   = ctl.fin;
				wr_addr = bot_dec;
				bot_d   = bot_dec;
				top_d   = rd_data;
			end
			dsre_pkg::SC_REV: begin
				rd_addr = bot_q;
				wr_en   = ctl.fin;
				wr_addr = top_idx;
				bot_d   = bot_inc;
				top_d   = rd_data;
			end
			default: begin
			end
		endcase
	end

	dsre_ram #(
		.WIDTH (dsre_pkg::DATA_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (top_q),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bot_q <= '0;
			sz_q  <= '0;
		end else if (ctl.fin) begin
			bot_q <= bot_d;
			sz_q  <= sz_d;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.fin) begin
			top_q <= top_d;
		end
	end

	assign view.empty    = (sz_q == '0);
	assign view.ge2      = (sz_q >= CW'(2));
	assign view.full     = (sz_q >= FULL_CNT);
	assign view.top      = top_q;
	assign view.top_next = (sz_d == '0) ? '0 : top_d;
	assign view.cnt_next = dsre_pkg::CNT_OUT_W'(sz_d);

endmodule

// ===== hdl/dsre_back.sv =====
`timescale 1ns / 1ps

module dsre_back (
	input  logic                clk,
	input  logic                arst_n,
	input  dsre_pkg::op_t       head,
	input  logic                head_valid,
	output logic                pop,
	input  dsre_pkg::stk_view_t a_view,
	input  dsre_pkg::stk_view_t b_view,
	output dsre_pkg::stk_ctl_t  a_ctl,
	output dsre_pkg::stk_ctl_t  b_ctl,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output dsre_pkg::rsp_t      rsp
);

	dsre_pkg::bk_state_t state_q;
	dsre_pkg::bk_state_t state_d;
	logic                rsp_valid_q;
	dsre_pkg::rsp_t      rsp_q;
	logic                start;
	logic                fin;
	logic [1:0]          status;
	dsre_pkg::stk_cmd_t  sc;
	dsre_pkg::stk_cmd_t  cmd_a;
	dsre_pkg::stk_cmd_t  cmd_b;

	// output slot is free now or is emptied at this edge
	assign start = head_valid && (!rsp_valid_q || !rsp_stall);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dsre_pkg::BK_IDLE: begin
				if (start) begin
					state_d = dsre_pkg::BK_EXEC;
				end
			end
			dsre_pkg::BK_EXEC: begin
				state_d = dsre_pkg::BK_IDLE;
			end
			default: begin
				state_d = dsre_pkg::BK_IDLE;
			end
		endcase
	end

	always_comb begin
		fin = 1'b0;
		unique case (state_q)
			dsre_pkg::BK_IDLE: fin = 1'b0;
			dsre_pkg::BK_EXEC: fin = 1'b1;
			default:           fin = 1'b0;
		endcase
	end

	assign pop = fin;

	// per-stack plan from the queue head and the stack fill levels
	always_comb begin
		status = dsre_pkg::STS_IGNORED;
		cmd_a  = dsre_pkg::SC_NONE;
		cmd_b  = dsre_pkg::SC_NONE;
		sc     = dsre_pkg::SC_NONE;
		unique case (head.kind)
			dsre_pkg::OP_SWAP: sc = dsre_pkg::SC_SWAP;
			dsre_pkg::OP_ROT:  sc = dsre_pkg::SC_ROT;
			dsre_pkg::OP_REV:  sc = dsre_pkg::SC_REV;
			default:           sc = dsre_pkg::SC_NONE;
		endcase
		unique case (head.kind) inside
			dsre_pkg::OP_LOAD: begin
				if (!a_view.full) begin
					cmd_a  = dsre_pkg::SC_PUSH;
					status = dsre_pkg::STS_DONE;
				end
			end
			dsre_pkg::OP_SWAP, dsre_pkg::OP_ROT, dsre_pkg::OP_REV: begin
				if (head.on_a) begin
					// both-stack form: B follows only when A succeeds
					if (a_view.ge2) begin
						cmd_a  = sc;
						status = dsre_pkg::STS_DONE;
						if (head.on_b && b_view.ge2) begin
							cmd_b = sc;
						end
					end
				end else if (b_view.ge2) begin
					cmd_b  = sc;
					status = dsre_pkg::STS_DONE;
				end
			end
			dsre_pkg::OP_MOVE_BA: begin
				if (b_view.empty) begin
					status = dsre_pkg::STS_POP_EMPTY;
				end else begin
					// full destination drops the popped entry
					cmd_b = dsre_pkg::SC_POP;
					if (!a_view.full) begin
						cmd_a  = dsre_pkg::SC_PUSH;
						status = dsre_pkg::STS_DONE;
					end
				end
			end
			dsre_pkg::OP_MOVE_AB: begin
				if (a_view.empty) begin
					status = dsre_pkg::STS_POP_EMPTY;
				end else begin
					cmd_a = dsre_pkg::SC_POP;
					if (!b_view.full) begin
						cmd_b  = dsre_pkg::SC_PUSH;
						status = dsre_pkg::STS_DONE;
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign a_ctl.cmd      = cmd_a;
	assign a_ctl.fin      = fin;
	assign a_ctl.push_val = (head.kind == dsre_pkg::OP_MOVE_BA) ? b_view.top : head.value;
	assign b_ctl.cmd      = cmd_b;
	assign b_ctl.fin      = fin;
	assign b_ctl.push_val = a_view.top;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dsre_pkg::BK_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (fin) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			rsp_q.status      <= status;
			rsp_q.a_top_value <= a_view.top_next;
			rsp_q.b_top_value <= b_view.top_next;
			rsp_q.a_count     <= a_view.cnt_next;
			rsp_q.b_count     <= b_view.cnt_next;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== hdl/dual_stack_rotate_engine_core.sv =====
`timescale 1ns / 1ps
// An accepted request waits in the front queue until the back end leaves IDLE for EXEC;
//   rsp_valid is registered at the end of EXEC. Each request takes a read issue step in
//   IDLE and a write/update step on each stack RAM in EXEC, and the next starts after EXEC.
// The front queue holds 2 requests, so req_stall rises only when both are used.
// Reset clears stack counts, bottom pointers, queue and response valid; the
//   stack RAMs are not cleared and need no clearing pass.

module dual_stack_rotate_engine_core #(
	parameter int DEPTH = dsre_pkg::DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  dsre_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output dsre_pkg::rsp_t rsp
);

	// front <-> back queue head
	dsre_pkg::op_t       head;
	logic                head_valid;
	logic                pop;

	// back <-> stacks
	dsre_pkg::stk_ctl_t  a_ctl;
	dsre_pkg::stk_ctl_t  b_ctl;
	dsre_pkg::stk_view_t a_view;
	dsre_pkg::stk_view_t b_view;

	// Front: classify the action code and park the request in a 2-deep queue.
	dsre_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid)
	);

	// Back: plans per-stack commands, runs the IDLE/EXEC sequence and holds
	// the response register. A new request starts while the previous
	// response is being taken.
	dsre_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.a_view     (a_view),
		.b_view     (b_view),
		.a_ctl      (a_ctl),
		.b_ctl      (b_ctl),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp)
	);

	// Stacks: ring buffer with cached top register. Rotations move the
	// bottom pointer and write one entry; swaps read the second entry.
	dsre_stack #(
		.DEPTH (DEPTH)
	) u_stack_a (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (a_ctl),
		.view   (a_view)
	);

	dsre_stack #(
		.DEPTH (DEPTH)
	) u_stack_b (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (b_ctl),
		.view   (b_view)
	);

endmodule

// ===== test/tb_dual_stack_rotate_engine_core.sv =====
`timescale 1ns / 1ps

module tb_dual_stack_rotate_engine_core;

	localparam int DEPTH = dsre_pkg::DEPTH_DEF;
	localparam int DW    = dsre_pkg::DATA_W;
	localparam int STK_A = 0;
	localparam int STK_B = 1;

	// quiet window (cycles) where neither side idles
	localparam int QUIET_LO = 1200;
	localparam int QUIET_HI = 2200;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	dsre_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	dsre_pkg::rsp_t rsp;

	dual_stack_rotate_engine_core #(.DEPTH(DEPTH)) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// shadow of both stacks
	logic [DW-1:0] stk_mem [2][DEPTH];
	int stk_bot [2];
	int stk_cnt [2];

	dsre_pkg::req_t pending_reqs[$];
	dsre_pkg::rsp_t expected_rsps[$];

	int errors = 0;
	int cyc = 0;
	int n_accepted = 0;
	int n_checked = 0;
	int n_status [3];

	// request-generator view of the counts only, used to steer phases
	int gen_a = 0;
	int gen_b = 0;

	function automatic int top_idx(int s);
		return (stk_bot[s] + stk_cnt[s] + DEPTH - 1) % DEPTH;
	endfunction

	function automatic logic [1:0] stk_push(int s, logic [DW-1:0] v);
		if (stk_cnt[s] >= DEPTH)
			return dsre_pkg::STS_IGNORED;
		stk_mem[s][(stk_bot[s] + stk_cnt[s]) % DEPTH] = v;
		stk_cnt[s]++;
		return dsre_pkg::STS_DONE;
	endfunction

	function automatic logic [1:0] stk_swap(int s);
		int hi;
		int lo;
		logic [DW-1:0] t;
		if (stk_cnt[s] < 2)
			return dsre_pkg::STS_IGNORED;
		hi = top_idx(s);
		lo = (stk_bot[s] + stk_cnt[s] + DEPTH - 2) % DEPTH;
		t = stk_mem[s][hi];
		stk_mem[s][hi] = stk_mem[s][lo];
		stk_mem[s][lo] = t;
		return dsre_pkg::STS_DONE;
	endfunction

	// top entry goes below the bottom
	function automatic logic [1:0] stk_rot(int s);
		logic [DW-1:0] v;
		int nb;
		if (stk_cnt[s] < 2)
			return dsre_pkg::STS_IGNORED;
		v = stk_mem[s][top_idx(s)];
		nb = (stk_bot[s] + DEPTH - 1) % DEPTH;
		stk_mem[s][nb] = v;
		stk_bot[s] = nb;
		return dsre_pkg::STS_DONE;
	endfunction

	// bottom entry goes on top
	function automatic logic [1:0] stk_rev(int s);
		logic [DW-1:0] v;
		if (stk_cnt[s] < 2)
			return dsre_pkg::STS_IGNORED;
		v = stk_mem[s][stk_bot[s]];
		stk_bot[s] = (stk_bot[s] + 1) % DEPTH;
		stk_mem[s][top_idx(s)] = v;
		return dsre_pkg::STS_DONE;
	endfunction

	// pop from src, push onto dst; entry lost if dst is full
	function automatic logic [1:0] stk_move(int src, int dst);
		logic [DW-1:0] v;
		if (stk_cnt[src] == 0)
			return dsre_pkg::STS_POP_EMPTY;
		v = stk_mem[src][top_idx(src)];
		stk_cnt[src]--;
		return stk_push(dst, v);
	endfunction

	function automatic dsre_pkg::rsp_t apply_action(dsre_pkg::req_t r);
		dsre_pkg::rsp_t o;
		logic [1:0] sts;
		logic [1:0] dummy;
		case (r.action)
			dsre_pkg::ACT_LOAD:    sts = stk_push(STK_A, r.value);
			dsre_pkg::ACT_SWAP_A:  sts = stk_swap(STK_A);
			dsre_pkg::ACT_SWAP_B:  sts = stk_swap(STK_B);
			dsre_pkg::ACT_SWAP_AB: begin
				sts = stk_swap(STK_A);
				if (sts == dsre_pkg::STS_DONE)
					dummy = stk_swap(STK_B);
			end
			dsre_pkg::ACT_ROT_A:   sts = stk_rot(STK_A);
			dsre_pkg::ACT_ROT_B:   sts = stk_rot(STK_B);
			dsre_pkg::ACT_ROT_AB:  begin
				sts = stk_rot(STK_A);
				if (sts == dsre_pkg::STS_DONE)
					dummy = stk_rot(STK_B);
			end
			dsre_pkg::ACT_REV_A:   sts = stk_rev(STK_A);
			dsre_pkg::ACT_REV_B:   sts = stk_rev(STK_B);
			dsre_pkg::ACT_REV_AB:  begin
				sts = stk_rev(STK_A);
				if (sts == dsre_pkg::STS_DONE)
					dummy = stk_rev(STK_B);
			end
			dsre_pkg::ACT_MOVE_BA: sts = stk_move(STK_B, STK_A);
			dsre_pkg::ACT_MOVE_AB: sts = stk_move(STK_A, STK_B);
			default:               sts = dsre_pkg::STS_IGNORED;
		endcase
		o.status      = sts;
		o.a_top_value = (stk_cnt[STK_A] != 0) ? stk_mem[STK_A][top_idx(STK_A)] : '0;
		o.b_top_value = (stk_cnt[STK_B] != 0) ? stk_mem[STK_B][top_idx(STK_B)] : '0;
		o.a_count     = dsre_pkg::CNT_OUT_W'(stk_cnt[STK_A]);
		o.b_count     = dsre_pkg::CNT_OUT_W'(stk_cnt[STK_B]);
		return o;
	endfunction

	// queue a request and track the counts it leaves behind
	function automatic void add_req(logic [3:0] act, logic [DW-1:0] v);
		dsre_pkg::req_t r;
		r.action = act;
		r.value  = v;
		pending_reqs.push_back(r);
		case (act)
			dsre_pkg::ACT_LOAD:    if (gen_a < DEPTH) gen_a++;
			dsre_pkg::ACT_MOVE_BA: if (gen_b > 0) begin
				gen_b--;
				if (gen_a < DEPTH) gen_a++;
			end
			dsre_pkg::ACT_MOVE_AB: if (gen_a > 0) begin
				gen_a--;
				if (gen_b < DEPTH) gen_b++;
			end
			default: ;
		endcase
	endfunction

	function automatic logic [DW-1:0] rand_value();
		if ($urandom_range(9) == 0) begin
			case ($urandom_range(3))
				0: return 32'h0000_0000;
				1: return 32'hFFFF_FFFF;
				2: return 32'h7FFF_FFFF;
				default: return 32'h8000_0000;
			endcase
		end
		return $urandom;
	endfunction

	// weighted pick: load / move A->B / move B->A, a few unused codes, rest mixed
	function automatic void add_rand(int w_load, int w_ab, int w_ba);
		int roll;
		logic [3:0] act;
		roll = $urandom_range(99);
		if (roll < w_load)
			act = dsre_pkg::ACT_LOAD;
		else if (roll < w_load + w_ab)
			act = dsre_pkg::ACT_MOVE_AB;
		else if (roll < w_load + w_ab + w_ba)
			act = dsre_pkg::ACT_MOVE_BA;
		else if (roll >= 97)
			act = 4'($urandom_range(12, 15));
		else
			act = 4'($urandom_range(dsre_pkg::ACT_SWAP_A, dsre_pkg::ACT_REV_AB));
		add_req(act, rand_value());
	endfunction

	task automatic report_field(string name, logic [DW-1:0] e, logic [DW-1:0] g);
		if (g !== e) begin
			$display("%0t: mismatch on %s: expected %0d (0x%h), actual %0d (0x%h)",
				$time, name, $signed(e), e, $signed(g), g);
			errors++;
		end
	endtask

	function automatic bit side_idles();
		return (cyc < QUIET_LO || cyc >= QUIET_HI) && ($urandom_range(99) < 19);
	endfunction

	// driver: predicts on each accepted request, then offers the next one
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall) begin
				expected_rsps.push_back(apply_action(req));
				n_accepted++;
			end
			if (!req_valid || !req_stall) begin
				if (pending_reqs.size() > 0 && !side_idles()) begin
					req       <= pending_reqs.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: compares each accepted response with the oldest prediction
	always @(posedge clk) begin
		dsre_pkg::rsp_t e;
		if (arst_n) begin
			cyc <= cyc + 1;
			if (rsp_valid && !rsp_stall) begin
				if (expected_rsps.size() == 0) begin
					$display("%0t: unexpected response, expected none, actual %p", $time, rsp);
					errors++;
				end else begin
					e = expected_rsps.pop_front();
					report_field("status", 32'(e.status), 32'(rsp.status));
					report_field("a_top_value", e.a_top_value, rsp.a_top_value);
					report_field("b_top_value", e.b_top_value, rsp.b_top_value);
					report_field("a_count", 32'(e.a_count), 32'(rsp.a_count));
					report_field("b_count", 32'(e.b_count), 32'(rsp.b_count));
					if (e.status < 3)
						n_status[e.status]++;
					n_checked++;
				end
			end
			rsp_stall <= side_idles();
		end
	end

	initial begin
		for (int s = 0; s < 2; s++) begin
			stk_bot[s] = 0;
			stk_cnt[s] = 0;
			for (int i = 0; i < DEPTH; i++)
				stk_mem[s][i] = '0;
		end
		for (int i = 0; i < 3; i++)
			n_status[i] = 0;

		// directed: empty stacks, unused codes, value extremes, one-entry cases
		add_req(dsre_pkg::ACT_SWAP_A, 32'h0);
		add_req(dsre_pkg::ACT_ROT_AB, 32'h0);
		add_req(dsre_pkg::ACT_REV_B, 32'h0);
		add_req(dsre_pkg::ACT_MOVE_BA, 32'h0);
		add_req(dsre_pkg::ACT_MOVE_AB, 32'h0);
		add_req(4'd15, 32'hFFFF_FFFF);
		add_req(dsre_pkg::ACT_LOAD, 32'h7FFF_FFFF);
		add_req(dsre_pkg::ACT_SWAP_AB, 32'h0);
		add_req(dsre_pkg::ACT_LOAD, 32'h8000_0000);
		add_req(dsre_pkg::ACT_SWAP_A, 32'h0);
		add_req(dsre_pkg::ACT_SWAP_AB, 32'h0);
		add_req(dsre_pkg::ACT_MOVE_AB, 32'h0);
		add_req(dsre_pkg::ACT_MOVE_AB, 32'h0);
		add_req(dsre_pkg::ACT_LOAD, 32'hFFFF_FFFF);
		add_req(dsre_pkg::ACT_LOAD, 32'h0000_0000);
		add_req(dsre_pkg::ACT_LOAD, 32'h1234_5678);
		add_req(dsre_pkg::ACT_MOVE_AB, 32'h0);
		add_req(dsre_pkg::ACT_SWAP_B, 32'h0);
		add_req(dsre_pkg::ACT_ROT_A, 32'h0);
		add_req(dsre_pkg::ACT_ROT_B, 32'h0);
		add_req(dsre_pkg::ACT_REV_A, 32'h0);
		add_req(dsre_pkg::ACT_ROT_AB, 32'h0);
		add_req(dsre_pkg::ACT_REV_AB, 32'h0);
		add_req(dsre_pkg::ACT_MOVE_BA, 32'h0);
		add_req(4'd12, 32'h0);

		// random: mixed warm-up
		repeat (40) add_rand(30, 15, 15);
		// fill A to the top, then hammer loads onto the full stack
		while (gen_a < DEPTH) add_rand(94, 1, 1);
		repeat (15) add_rand(60, 0, 0);
		// drain A into B, then top B off to full and move onto it
		while (gen_a > 0) add_rand(1, 94, 1);
		while (gen_b < DEPTH) begin
			if (gen_a == 0)
				add_req(dsre_pkg::ACT_LOAD, rand_value());
			else
				add_rand(45, 50, 0);
		end
		repeat (15) add_rand(40, 50, 0);
		// back toward B->A traffic
		repeat (30) add_rand(10, 10, 40);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_reqs.size() > 0 || req_valid) @(posedge clk);
		while (expected_rsps.size() > 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (expected_rsps.size() > 0) begin
			$display("%0t: %0d expected responses never arrived", $time, expected_rsps.size());
			errors++;
		end

		$display("Ran %0d requests (%0d responses checked): done %0d, ignored %0d, pop-empty %0d",
			n_accepted, n_checked, n_status[dsre_pkg::STS_DONE],
			n_status[dsre_pkg::STS_IGNORED], n_status[dsre_pkg::STS_POP_EMPTY]);
		$display("Covered both stacks filled to depth %0d, overflow, ring wrap and empty pops",
			DEPTH);
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches", errors);
			$display("== FAIL ==");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("%0t: timeout, %0d requests pending, %0d responses outstanding",
			$time, pending_reqs.size(), expected_rsps.size());
		$display("== FAIL ==");
		$finish;
	end

endmodule
